### rtl/core/lfu_pr_pkg.sv
package lfu_pr_pkg;

  localparam int FRAMES     = 16;
  localparam int PAGE_BITS  = 16;
  localparam int STAMP_BITS = 32;
  localparam int COUNT_W    = 16;
  localparam int FAULT_W    = 32;
  localparam int CFG_W      = 5;
  localparam int IDX_W      = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W      = $clog2(FRAMES + 1);

  typedef logic [PAGE_BITS-1:0]  page_t;
  typedef logic [STAMP_BITS-1:0] stamp_t;
  typedef logic [COUNT_W-1:0]    count_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SCAN,
    ST_EVICT
  } state_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic active;
    logic load;
    logic bump;
    idx_t idx;
  } cell_ctl_t;

  // running victim candidate handed down the chain
  typedef struct packed {
    logic   found;
    count_t count;
    stamp_t stamp;
    idx_t   idx;
    page_t  page;
  } best_t;

endpackage

### rtl/core/lfu_pr_cell.sv
module lfu_pr_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  lfu_pr_pkg::cell_ctl_t ctl,
  input  lfu_pr_pkg::page_t   key_page,
  input  lfu_pr_pkg::stamp_t  new_stamp,
  input  lfu_pr_pkg::best_t   best_in,
  output lfu_pr_pkg::best_t   best_out,
  output logic                match
);
  import lfu_pr_pkg::*;

  logic   valid_r;
  page_t  page_r;
  count_t count_r;
  stamp_t stamp_r;
  best_t  best_r, best_nxt;
  best_t  self_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.load) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      page_r  <= key_page;
      count_r <= COUNT_W'(1);
      stamp_r <= new_stamp;
    end else if (ctl.bump && (count_r != '1)) begin
      count_r <= count_r + COUNT_W'(1);
    end
  end

  assign match = valid_r && ctl.active && (page_r == key_page);

  always_comb begin
    self_b.found = 1'b1;
    self_b.count = count_r;
    self_b.stamp = stamp_r;
    self_b.idx   = ctl.idx;
    self_b.page  = page_r;
    best_nxt = best_in;
    if (ctl.active && valid_r) begin
      if (!best_in.found) begin
        best_nxt = self_b;
      end else if ((count_r < best_in.count) ||
                   ((count_r == best_in.count) && (stamp_r < best_in.stamp))) begin
        best_nxt = self_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    best_r <= best_nxt;
  end

  assign best_out = best_r;

endmodule

### rtl/core/lfu_page_replacement.sv
// a hit or a fill is settled in ST_LOOK and strobed from the registered result beat
// on an eviction: ST_LOOK, then ST_SCAN for the victim pass down the cell chain, then ST_EVICT
// throughput: one beat at a time, busy drops in the strobe cycle and its closing edge takes start
// results are strobed for one cycle, the receiver cannot stall
// synchronous active-low reset clears valid bits and fill/stamp/fault counters, frame count to 16
module lfu_page_replacement (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_page_number,
  output logic        out_valid,
  output logic        out_hit,
  output logic [3:0]  out_slot,
  output logic        out_evicted_valid,
  output logic [15:0] out_evicted_page,
  output logic [31:0] out_fault_total,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lfu_pr_pkg::*;

  localparam logic REG_FRAMES = 1'b0;

  state_t state_r, state_nxt;
  page_t  page_r;
  cnt_t   n_r, n_eff;
  cnt_t   scan_r, scan_nxt;
  cnt_t   filled_r, filled_nxt;
  stamp_t ref_r, ref_nxt;
  logic [FAULT_W-1:0] fault_r, fault_nxt;
  logic [CFG_W-1:0]   cfg_r;

  cell_ctl_t ctl [FRAMES];
  best_t     chain [FRAMES];
  logic [FRAMES-1:0] match;

  logic  hit_any;
  idx_t  hit_idx;
  logic  do_load, do_bump, do_out, do_evict;
  idx_t  load_idx;
  best_t victim;

  logic        out_valid_r, out_hit_r, out_evicted_valid_r;
  logic [3:0]  out_slot_r;
  logic [15:0] out_evicted_page_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_W'(16);
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_FRAMES)) begin
      cfg_r <= pwdata[CFG_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FRAMES) ? 32'(cfg_r) : 32'd0;

  always_comb begin
    if (cfg_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (int'(cfg_r) > FRAMES) begin
      n_eff = CNT_W'(FRAMES);
    end else begin
      n_eff = CNT_W'(cfg_r);
    end
  end

  // cell chain
  for (genvar k = 0; k < FRAMES; k++) begin : g_cell
    best_t prev;
    if (k == 0) begin : g_head
      assign prev = '0;
    end else begin : g_link
      assign prev = chain[k-1];
    end
    lfu_pr_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl[k]),
      .key_page  (page_r),
      .new_stamp (ref_r),
      .best_in   (prev),
      .best_out  (chain[k]),
      .match     (match[k])
    );
  end

  assign victim = chain[FRAMES-1];

  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int k = FRAMES - 1; k >= 0; k--) begin
      if (match[k]) begin
        hit_any = 1'b1;
        hit_idx = IDX_W'(k);
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      scan_r   <= '0;
      filled_r <= '0;
      ref_r    <= '0;
      fault_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      scan_r   <= scan_nxt;
      filled_r <= filled_nxt;
      ref_r    <= ref_nxt;
      fault_r  <= fault_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      page_r <= page_t'(in_page_number);
      n_r    <= n_eff;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    scan_nxt   = scan_r;
    filled_nxt = filled_r;
    ref_nxt    = ref_r;
    fault_nxt  = fault_r;
    do_load    = 1'b0;
    do_bump    = 1'b0;
    do_out     = 1'b0;
    do_evict   = 1'b0;
    load_idx   = hit_idx;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (hit_any) begin
          do_bump   = 1'b1;
          do_out    = 1'b1;
          state_nxt = ST_IDLE;
        end else if (filled_r < n_r) begin
          do_load    = 1'b1;
          do_out     = 1'b1;
          load_idx   = filled_r[IDX_W-1:0];
          filled_nxt = filled_r + CNT_W'(1);
          state_nxt  = ST_IDLE;
        end else begin
          scan_nxt  = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        scan_nxt = scan_r + CNT_W'(1);
        if (scan_r == CNT_W'(FRAMES - 1)) begin
          state_nxt = ST_EVICT;
        end
      end
      ST_EVICT: begin
        do_load   = 1'b1;
        do_out    = 1'b1;
        do_evict  = 1'b1;
        load_idx  = victim.idx;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (do_out) begin
      ref_nxt = ref_r + STAMP_BITS'(1);
      if (do_load && (fault_r != '1)) begin
        fault_nxt = fault_r + FAULT_W'(1);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < FRAMES; k++) begin
      ctl[k].active = (CNT_W'(k) < n_r);
      ctl[k].load   = do_load && (load_idx == IDX_W'(k));
      ctl[k].bump   = do_bump && (hit_idx == IDX_W'(k));
      ctl[k].idx    = IDX_W'(k);
    end
  end

  assign busy = (state_r != ST_IDLE);

  // result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= do_out;
    end
  end

  always_ff @(posedge clk) begin
    if (do_out) begin
      out_hit_r           <= do_bump;
      out_slot_r          <= 4'(load_idx);
      out_evicted_valid_r <= do_evict;
      out_evicted_page_r  <= do_evict ? 16'(victim.page) : 16'd0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_slot          = out_slot_r;
  assign out_evicted_valid = out_evicted_valid_r;
  assign out_evicted_page  = out_evicted_page_r;
  assign out_fault_total   = 32'(fault_r);

  a_out_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while busy");

  a_evict_not_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_evicted_valid) |-> !out_hit)
    else $error("eviction reported on a hit");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_fault_mono: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> (fault_r >= $past(fault_r)))
    else $error("fault count decreased");

  a_evict_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVICT) |-> victim.found)
    else $error("no victim found at eviction");

endmodule

### sim/tb_lfu_page_replacement.sv
`timescale 1ns / 1ps

module tb_lfu_page_replacement;
  import lfu_pr_pkg::*;

  localparam logic [2:0] ADDR_FRAMES_IN_USE = 3'd0;
  localparam logic [2:0] ADDR_UNMAPPED      = 3'd4;
  localparam int SETTLE_CYCLES  = FRAMES + 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_BEATS    = 160;

  typedef struct packed {
    logic        hit;
    logic [3:0]  slot;
    logic        evicted_valid;
    logic [15:0] evicted_page;
    logic [31:0] fault_total;
  } page_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] in_page_number = '0;
  logic        out_valid;
  logic        out_hit;
  logic [3:0]  out_slot;
  logic        out_evicted_valid;
  logic [15:0] out_evicted_page;
  logic [31:0] out_fault_total;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // mirror of the replacement state
  page_t       frame_page  [FRAMES];
  logic        frame_used  [FRAMES];
  count_t      frame_uses  [FRAMES];
  stamp_t      frame_stamp [FRAMES];
  stamp_t      ref_index;
  int unsigned fill_level;
  logic [31:0] fault_count;
  logic [4:0]  frames_reg;

  page_result_t pending_results[$];
  page_result_t got_result;
  int           mismatches = 0;
  int           stall_cycles = 0;
  logic         quiet_stretch = 1'b0;

  always #2 clk = ~clk;

  lfu_page_replacement dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_page_number    (in_page_number),
    .out_valid         (out_valid),
    .out_hit           (out_hit),
    .out_slot          (out_slot),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_total   (out_fault_total),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  function automatic page_result_t lfu_lookup(input page_t pg);
    int unsigned  n;
    int unsigned  k;
    int unsigned  best;
    logic         found;
    page_result_t r;
    n = frames_reg;
    if (n < 1) n = 1;
    if (n > FRAMES) n = FRAMES;
    r = '0;
    found = 1'b0;
    for (k = 0; k < n; k++) begin
      if (!found && frame_used[k] && frame_page[k] == pg) begin
        found = 1'b1;
        r.slot = k[3:0];
      end
    end
    if (found) begin
      r.hit = 1'b1;
      if (frame_uses[r.slot] != '1) frame_uses[r.slot] = frame_uses[r.slot] + 1'b1;
    end else begin
      if (fault_count != '1) fault_count = fault_count + 1;
      if (fill_level < n) begin
        r.slot = fill_level[3:0];
        fill_level++;
      end else begin
        best = 0;
        for (k = 1; k < n; k++) begin
          if (frame_uses[k] < frame_uses[best] ||
              (frame_uses[k] == frame_uses[best] && frame_stamp[k] < frame_stamp[best]))
            best = k;
        end
        r.slot = best[3:0];
        r.evicted_valid = 1'b1;
        r.evicted_page = frame_page[best];
      end
      frame_page[r.slot]  = pg;
      frame_used[r.slot]  = 1'b1;
      frame_uses[r.slot]  = count_t'(1);
      frame_stamp[r.slot] = ref_index;
    end
    ref_index = ref_index + 1;
    r.fault_total = fault_count;
    return r;
  endfunction

  task automatic log_mismatch(input string what, input page_result_t want,
                              input page_result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: exp hit=%0b slot=%0d ev=%0b evp=%h faults=%0d",
               $realtime, what, want.hit, want.slot, want.evicted_valid,
               want.evicted_page, want.fault_total,
               " / got hit=%0b slot=%0d ev=%0b evp=%h faults=%0d",
               got.hit, got.slot, got.evicted_valid, got.evicted_page, got.fault_total);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      got_result = {out_hit, out_slot, out_evicted_valid, out_evicted_page, out_fault_total};
      if (pending_results.size() == 0)
        log_mismatch("unexpected result", '0, got_result);
      else if (got_result !== pending_results[0])
        log_mismatch("result mismatch", pending_results.pop_front(), got_result);
      else
        void'(pending_results.pop_front());
    end
  end

  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_page(input page_t pg);
    int gap;
    if (!quiet_stretch && $urandom_range(0, 99) < 12) begin
      gap = $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_page_number <= pg;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(lfu_lookup(pg));
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_FRAMES_IN_USE) frames_reg = data[4:0];
    @(posedge clk);
  endtask

  task automatic check_frames_reg();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_FRAMES_IN_USE;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata[4:0] !== frames_reg) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t frames_in_use readback: exp %0d got %0d",
                 $realtime, frames_reg, prdata[4:0]);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frames(input logic [4:0] value);
    drain_results();
    apb_write(ADDR_FRAMES_IN_USE, {27'd0, value});
    check_frames_reg();
  endtask

  task automatic test_fill_and_hit();
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'hA5A5);
    send_page(16'h5A5A);
    send_page(16'hFFFF);
    send_page(16'h0000);
    send_page(16'h0000);
  endtask

  // shrink below the filled frames so every miss goes to the victim search
  task automatic test_victim_order();
    set_frames(5'd3);
    send_page(16'h1234);
    send_page(16'h4321);
    send_page(16'h4321);
    send_page(16'h4321);
    send_page(16'h0F0F);
    send_page(16'hF0F0);
  endtask

  task automatic test_frame_limits();
    set_frames(5'd0);
    send_page(16'h0001);
    send_page(16'h0002);
    send_page(16'h0002);
    set_frames(5'd31);
    send_page(16'h8000);
    send_page(16'h0002);
    set_frames(5'd17);
    send_page(16'h7FFF);
    set_frames(5'd16);
    drain_results();
    apb_write(ADDR_UNMAPPED, 32'd1);
    check_frames_reg();
    send_page(16'h0003);
  endtask

  task automatic test_random_stream();
    logic [4:0]  phase_frames [9];
    page_t       pool [$];
    int unsigned eff;
    int          pick;
    phase_frames = '{5'd16, 5'd1, 5'd4, 5'd0, 5'd8, 5'd31, 5'd2, 5'd17, 5'd12};
    phase_frames[8] = $urandom_range(0, 31);
    for (int ph = 0; ph < 9; ph++) begin
      set_frames(phase_frames[ph]);
      eff = phase_frames[ph];
      if (eff < 1) eff = 1;
      if (eff > FRAMES) eff = FRAMES;
      pool.delete();
      repeat (eff + $urandom_range(0, 6)) pool.push_back(page_t'($urandom));
      quiet_stretch = (ph == 2);
      for (int i = 0; i < PHASE_BEATS; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70)
          send_page(pool[$urandom_range(0, pool.size() - 1)]);
        else if (pick < 85)
          send_page(page_t'($urandom_range(0, 15)));
        else
          send_page(page_t'($urandom));
      end
    end
    quiet_stretch = 1'b0;
  endtask

  initial begin
    for (int k = 0; k < FRAMES; k++) begin
      frame_page[k]  = '0;
      frame_used[k]  = 1'b0;
      frame_uses[k]  = '0;
      frame_stamp[k] = '0;
    end
    ref_index   = '0;
    fill_level  = 0;
    fault_count = '0;
    frames_reg  = 5'd16;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fill_and_hit();
    test_victim_order();
    test_frame_limits();
    test_random_stream();
    drain_results();
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
